// File: rtl/bed_pkg.sv
// Shared types and constants for the byte entropy detector.
package bed_pkg;

  localparam int MAX_LEN_DEF = 256;
  localparam int LOG_FRAC    = 24;
  localparam int OUT_FRAC    = 12;
  localparam int Q_BITS      = 17;

  localparam logic [15:0] THR_RESET = 16'd16384;
  localparam logic [15:0] ENT_MAX   = 16'h8000;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       has_byte;
    logic       last_byte;
  } bed_req_t;

  typedef struct packed {
    logic        low_entropy;
    logic [15:0] entropy_q12;
    logic [8:0]  byte_count;
  } bed_res_t;

endpackage

// File: rtl/byte_entropy_detector.sv
// Byte entropy detector: 256-bin histogram, bin walk, entropy divide.
// Each counted byte is accepted, then its bin is updated; other requests are handled on acceptance.
// The last request then computes n*log2(n), walks all 256 bins (each bin of 2 or more takes
// 24 squarings on the shared multiplier) and then divides.
// The result strobe is one cycle wide and the receiver cannot stall it.
// Reset runs a histogram clearing pass over all 256 bins (busy high); threshold = 4.0.
module byte_entropy_detector #(
  parameter int MAX_LEN = bed_pkg::MAX_LEN_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  bed_pkg::bed_req_t request,
  output logic              done,
  output bed_pkg::bed_res_t result,
  input  logic              cfg_we,
  input  logic [15:0]       cfg_data
);
  import bed_pkg::*;

  localparam int CW  = $clog2(MAX_LEN + 1);
  localparam int EW  = $clog2(CW);
  localparam int LW  = LOG_FRAC + EW;
  localparam int TW  = CW + LW;
  localparam int DW  = TW - OUT_FRAC;
  localparam int DVW = CW + Q_BITS;
  localparam int XW  = (DW > DVW) ? DW : DVW;
  localparam int KW  = $clog2(Q_BITS);

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_INC, S_TOT, S_BLD, S_BLOG, S_DIVS, S_DSTEP, S_FIN
  } state_t;

  state_t             state;
  logic [15:0]        thr;
  logic [CW-1:0]      cnt;
  logic [7:0]         bin;
  logic [7:0]         byte_r;
  logic               last_r;
  logic               lastbin;
  logic               cgo;
  logic [CW-1:0]      cx;
  logic               cdone;
  logic [TW-1:0]      cterm;
  logic [TW-1:0]      total;
  logic [TW-1:0]      sum;
  logic [XW-1:0]      rem;
  logic [XW-1:0]      dv;
  logic [Q_BITS-1:0]  q;
  logic [KW-1:0]      k;
  logic               ovf;

  logic [CW-1:0]      hist [256];
  logic [CW-1:0]      rdata;
  logic [7:0]         rd_addr;
  logic               we;
  logic [7:0]         wa;
  logic [CW-1:0]      wd;

  logic               take;
  logic [TW-1:0]      diff;
  logic [XW-1:0]      dh_x;
  logic [XW-1:0]      n_x;
  logic               ovf_c;
  logic [15:0]        ent;

  bed_clog #(.CW(CW), .TW(TW)) u_clog (
    .clk  (clk),
    .rst  (rst),
    .go   (cgo),
    .x    (cx),
    .done (cdone),
    .term (cterm)
  );

  assign busy  = (state != S_IDLE);
  assign take  = request.has_byte && (cnt < CW'(MAX_LEN));
  assign diff  = (total > sum) ? (total - sum) : '0;
  assign dh_x  = XW'(diff >> OUT_FRAC);
  assign n_x   = XW'(cnt);
  assign ovf_c = (dh_x >= (n_x << Q_BITS));
  assign ent   = ovf ? ENT_MAX : ((q > {1'b0, ENT_MAX}) ? ENT_MAX : q[15:0]);

  always_comb begin
    unique case (state)
      S_IDLE:  rd_addr = request.byte_value;
      S_BLD:   rd_addr = bin + 8'd1;
      default: rd_addr = bin;
    endcase
    we = 1'b0;
    wa = bin;
    wd = '0;
    unique case (state)
      S_CLR, S_BLD: we = 1'b1;
      S_INC: begin
        we = 1'b1;
        wa = byte_r;
        wd = rdata + 1'b1;
      end
      default: we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      hist[wa] <= wd;
    end
    rdata <= hist[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= THR_RESET;
    end else if (cfg_we) begin
      thr <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      bin   <= '0;
      cnt   <= '0;
      done  <= 1'b0;
      cgo   <= 1'b0;
    end else begin
      done <= 1'b0;
      cgo  <= 1'b0;
      unique case (state)
        S_CLR: begin
          bin <= bin + 8'd1;
          if (bin == 8'd255) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            if (take) begin
              byte_r <= request.byte_value;
              last_r <= request.last_byte;
              state  <= S_INC;
            end else if (request.last_byte) begin
              if (cnt == '0) begin
                result <= '0;
                done   <= 1'b1;
              end else begin
                cgo   <= 1'b1;
                cx    <= cnt;
                bin   <= '0;
                state <= S_TOT;
              end
            end
          end
        end
        S_INC: begin
          cnt <= CW'(cnt + 1'b1);
          if (last_r) begin
            cgo   <= 1'b1;
            cx    <= CW'(cnt + 1'b1);
            bin   <= '0;
            state <= S_TOT;
          end else begin
            state <= S_IDLE;
          end
        end
        S_TOT: begin
          if (cdone) begin
            total <= cterm;
            sum   <= '0;
            state <= S_BLD;
          end
        end
        S_BLD: begin
          bin     <= bin + 8'd1;
          lastbin <= (bin == 8'd255);
          if (rdata > CW'(1)) begin
            cgo   <= 1'b1;
            cx    <= rdata;
            state <= S_BLOG;
          end else if (bin == 8'd255) begin
            state <= S_DIVS;
          end
        end
        S_BLOG: begin
          if (cdone) begin
            sum   <= sum + cterm;
            state <= lastbin ? S_DIVS : S_BLD;
          end
        end
        S_DIVS: begin
          rem   <= dh_x;
          dv    <= n_x << (Q_BITS - 1);
          ovf   <= ovf_c;
          q     <= '0;
          k     <= KW'(Q_BITS - 1);
          state <= ovf_c ? S_FIN : S_DSTEP;
        end
        S_DSTEP: begin
          if (rem >= dv) begin
            rem  <= rem - dv;
            q[k] <= 1'b1;
          end
          dv <= dv >> 1;
          if (k == '0) begin
            state <= S_FIN;
          end else begin
            k <= k - 1'b1;
          end
        end
        S_FIN: begin
          result.low_entropy <= (ent < thr);
          result.entropy_q12 <= ent;
          result.byte_count  <= 9'(cnt);
          done  <= 1'b1;
          cnt   <= '0;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/bed_clog.sv
// Iterative c*log2(c) unit: repeated squaring on one shared 32x32 multiplier.
module bed_clog #(
  parameter int CW = 9,
  parameter int TW = CW + bed_pkg::LOG_FRAC + $clog2(CW)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          go,
  input  logic [CW-1:0] x,
  output logic          done,
  output logic [TW-1:0] term
);
  import bed_pkg::*;

  localparam int EW = $clog2(CW);
  localparam int LW = LOG_FRAC + EW;
  localparam int KW = $clog2(LOG_FRAC);

  typedef enum logic [2:0] {C_IDLE, C_SQ, C_NORM, C_TM, C_FIN} cstate_t;

  cstate_t        state;
  logic [CW-1:0]  xv;
  logic [31:0]    m;
  logic [LW-1:0]  r;
  logic [KW-1:0]  k;
  logic [63:0]    prod;
  logic [EW-1:0]  e;
  logic [4:0]     sh;
  logic [31:0]    op_a;
  logic [31:0]    op_b;
  logic [63:0]    mul;
  logic [32:0]    t;

  always_comb begin
    e = '0;
    for (int i = 0; i < CW; i++) begin
      if (x[i]) begin
        e = EW'(i);
      end
    end
  end

  assign sh   = 5'd31 - 5'(e);
  assign op_a = (state == C_TM) ? 32'(xv) : m;
  assign op_b = (state == C_TM) ? 32'(r)  : m;
  assign mul  = 64'(op_a) * 64'(op_b);
  assign t    = prod[63:31];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        C_IDLE: begin
          if (go) begin
            xv <= x;
            if (x <= CW'(1)) begin
              term <= '0;
              done <= 1'b1;
            end else begin
              m     <= 32'(x) << sh;
              r     <= {e, {LOG_FRAC{1'b0}}};
              k     <= KW'(LOG_FRAC - 1);
              state <= C_SQ;
            end
          end
        end
        C_SQ: begin
          prod  <= mul;
          state <= C_NORM;
        end
        C_NORM: begin
          if (t[32]) begin
            m    <= t[32:1];
            r[k] <= 1'b1;
          end else begin
            m <= t[31:0];
          end
          if (k == '0) begin
            state <= C_TM;
          end else begin
            k     <= k - 1'b1;
            state <= C_SQ;
          end
        end
        C_TM: begin
          prod  <= mul;
          state <= C_FIN;
        end
        C_FIN: begin
          term  <= prod[TW-1:0];
          done  <= 1'b1;
          state <= C_IDLE;
        end
        default: state <= C_IDLE;
      endcase
    end
  end

endmodule

// File: tb/tb.sv
// Testbench for byte_entropy_detector: directed and random messages scored by an in-bench entropy predictor.
module tb;
  import bed_pkg::*;

  localparam int STALL_LIMIT = 50000;
  localparam int PHASE_ITEMS = 30;
  localparam int DRAIN_WAIT  = 20;
  localparam int TAIL_WAIT   = 200;

  typedef struct {
    bed_req_t req;
    bit       drain;
  } queued_req_t;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        start    = 1'b0;
  logic        busy;
  bed_req_t    request  = '0;
  logic        done;
  bed_res_t    result;
  logic        cfg_we   = 1'b0;
  logic [15:0] cfg_data = '0;

  byte_entropy_detector uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .request(request),
    .done(done),
    .result(result),
    .cfg_we(cfg_we),
    .cfg_data(cfg_data)
  );

  queued_req_t pending_requests[$];
  bed_res_t    expected_verdicts[$];
  bed_res_t    oldest_verdict;
  int unsigned bin_count[256];
  int unsigned msg_bytes = 0;
  logic [15:0] thr_shadow = THR_RESET;
  int          idle_pct = 0;
  int          err_count = 0;
  int          pushed_cnt = 0;
  int          taken_cnt = 0;
  int          phase_items = 0;
  int          stall_cycles = 0;
  logic        req_taken = 1'b0;

  initial forever #5 clk = ~clk;

  // log2 of x as unsigned Q.24 by repeated squaring of the mantissa
  function automatic logic [63:0] log2_q24(input int unsigned x);
    int unsigned e;
    logic [63:0] m;
    logic [63:0] r;
    int i;
    if (x == 0) return 64'd0;
    e = 0;
    while (e < 31 && (x >> (e + 1)) != 0) e++;
    m = 64'(x) << (31 - e);
    r = 64'(e) << LOG_FRAC;
    for (i = LOG_FRAC - 1; i >= 0; i--) begin
      m = (m * m) >> 31;
      if (m >= 64'h1_0000_0000) begin
        m = m >> 1;
        r[i] = 1'b1;
      end
    end
    return r;
  endfunction

  task automatic clear_bins();
    foreach (bin_count[i]) bin_count[i] = 0;
    msg_bytes = 0;
  endtask

  task automatic count_and_score(input bed_req_t r);
    logic [63:0] total;
    logic [63:0] sum;
    logic [63:0] diff;
    logic [63:0] ent;
    bed_res_t v;
    if (r.has_byte && msg_bytes < MAX_LEN_DEF) begin
      bin_count[r.byte_value]++;
      msg_bytes++;
    end
    if (r.last_byte) begin
      ent = 64'd0;
      v = '0;
      if (msg_bytes > 0) begin
        total = 64'(msg_bytes) * log2_q24(msg_bytes);
        sum = 64'd0;
        foreach (bin_count[i])
          if (bin_count[i] != 0) sum += 64'(bin_count[i]) * log2_q24(bin_count[i]);
        diff = (total > sum) ? total - sum : 64'd0;
        ent = (diff << OUT_FRAC) / (64'(msg_bytes) << LOG_FRAC);
        if (ent > 64'(ENT_MAX)) ent = 64'(ENT_MAX);
        v.low_entropy = (ent < 64'(thr_shadow));
      end
      v.entropy_q12 = ent[15:0];
      v.byte_count = msg_bytes[8:0];
      expected_verdicts.push_back(v);
      clear_bins();
    end
  endtask

  task automatic flag_mismatch(input string what, input int unsigned got, input int unsigned want);
    $display("MISMATCH %s: got %0d expected %0d", what, got, want);
    err_count++;
  endtask

  // monitor and predictor
  always @(posedge clk) begin
    if (rst) begin
      clear_bins();
      thr_shadow = THR_RESET;
      req_taken = 1'b0;
    end else begin
      if (done) begin
        if (expected_verdicts.size() == 0) begin
          flag_mismatch("result with none pending", result.entropy_q12, 0);
        end else begin
          oldest_verdict = expected_verdicts.pop_front();
          if (result.low_entropy !== oldest_verdict.low_entropy)
            flag_mismatch("low_entropy", result.low_entropy, oldest_verdict.low_entropy);
          if (result.entropy_q12 !== oldest_verdict.entropy_q12)
            flag_mismatch("entropy_q12", result.entropy_q12, oldest_verdict.entropy_q12);
          if (result.byte_count !== oldest_verdict.byte_count)
            flag_mismatch("byte_count", result.byte_count, oldest_verdict.byte_count);
        end
      end
      req_taken = start && !busy;
      if (req_taken) begin
        count_and_score(request);
        taken_cnt++;
      end
      if (cfg_we) thr_shadow = cfg_data;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (done || (start && !busy)) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("byte_entropy_detector test failed");
        $finish;
      end
    end
  end

  // request driver
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!start || req_taken) begin
      if (pending_requests.size() != 0 &&
          !(pending_requests[0].drain && expected_verdicts.size() != 0) &&
          $urandom_range(99, 0) >= idle_pct) begin
        start <= 1'b1;
        request <= pending_requests[0].req;
        pending_requests.delete(0);
      end else begin
        start <= 1'b0;
      end
    end
  end

  task automatic queue_item(input logic [7:0] b, input bit has, input bit last, input bit drain);
    queued_req_t q;
    q.req.byte_value = b;
    q.req.has_byte = has;
    q.req.last_byte = last;
    q.drain = drain;
    pending_requests.push_back(q);
    pushed_cnt++;
    if (has || last) phase_items++;
  endtask

  task automatic queue_message(input int len, input int alphabet, input bit drain);
    logic [7:0] base;
    logic [7:0] b;
    bit empty_end;
    bit first;
    int k;
    base = 8'($urandom_range(255, 0));
    empty_end = (len == 0) || ($urandom_range(3, 0) == 0);
    first = drain;
    for (k = 0; k < len; k++) begin
      if ($urandom_range(9, 0) == 0) begin
        queue_item(8'($urandom_range(255, 0)), 1'b0, 1'b0, first);
        first = 1'b0;
      end
      if (alphabet >= 256) b = 8'($urandom_range(255, 0));
      else b = 8'(base + $urandom_range(alphabet - 1, 0));
      queue_item(b, 1'b1, (k == len - 1) && !empty_end, first);
      first = 1'b0;
    end
    if (empty_end) queue_item(8'($urandom_range(255, 0)), 1'b0, 1'b1, first);
  endtask

  // every byte value once, then bytes past the length limit
  task automatic queue_all_values(input int extra);
    logic [7:0] perm[256];
    logic [7:0] t;
    int i;
    int j;
    foreach (perm[i]) perm[i] = 8'(i);
    for (i = 255; i > 0; i--) begin
      j = $urandom_range(i, 0);
      t = perm[i];
      perm[i] = perm[j];
      perm[j] = t;
    end
    for (i = 0; i < 256; i++) queue_item(perm[i], 1'b1, 1'b0, 1'b0);
    for (i = 0; i < extra; i++) queue_item(8'($urandom_range(255, 0)), 1'b1, i == extra - 1, 1'b0);
  endtask

  task automatic random_phase(input int pct, input bit heavy_drain);
    int r;
    int len;
    int alpha;
    idle_pct = pct;
    phase_items = 0;
    while (phase_items < PHASE_ITEMS) begin
      r = $urandom_range(99, 0);
      if (r < 5) begin
        len = 0;
        alpha = 1;
      end else if (r < 8) begin
        len = $urandom_range(300, 200);
        alpha = $urandom_range(256, 1);
      end else begin
        len = $urandom_range(12, 1);
        case ($urandom_range(4, 0))
          0: alpha = 1;
          1: alpha = 2;
          2: alpha = 4;
          3: alpha = 16;
          default: alpha = 256;
        endcase
      end
      queue_message(len, alpha,
                    heavy_drain ? ($urandom_range(3, 0) == 0) : ($urandom_range(19, 0) == 0));
    end
  endtask

  task automatic wait_idle();
    while (taken_cnt != pushed_cnt || expected_verdicts.size() != 0 || busy) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  task automatic set_threshold(input logic [15:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed messages at the reset threshold
    queue_item(8'h00, 1'b0, 1'b1, 1'b0);
    queue_item(8'h00, 1'b1, 1'b1, 1'b0);
    queue_item(8'hFF, 1'b0, 1'b0, 1'b0);
    queue_item(8'hFF, 1'b1, 1'b0, 1'b0);
    queue_item(8'h00, 1'b1, 1'b1, 1'b0);
    queue_item(8'h55, 1'b1, 1'b0, 1'b1);
    queue_item(8'hAA, 1'b1, 1'b0, 1'b0);
    queue_item(8'h0F, 1'b1, 1'b0, 1'b0);
    queue_item(8'hF0, 1'b1, 1'b0, 1'b0);
    queue_item(8'h00, 1'b0, 1'b1, 1'b0);
    queue_item(8'h7E, 1'b1, 1'b0, 1'b0);
    queue_item(8'h7E, 1'b1, 1'b0, 1'b0);
    queue_item(8'h7E, 1'b1, 1'b0, 1'b0);
    queue_item(8'h7E, 1'b1, 1'b1, 1'b0);
    queue_item(8'h81, 1'b0, 1'b0, 1'b0);
    queue_item(8'hC3, 1'b1, 1'b1, 1'b0);
    queue_item(8'h3C, 1'b1, 1'b0, 1'b1);
    queue_item(8'hC3, 1'b1, 1'b0, 1'b0);
    queue_item(8'h3C, 1'b1, 1'b1, 1'b0);

    random_phase(0, 1'b0);
    wait_idle();
    set_threshold(16'h0000);
    random_phase(46, 1'b1);
    wait_idle();
    set_threshold(16'h8000);
    queue_all_values(20);
    random_phase(11, 1'b0);
    wait_idle();
    set_threshold(16'($urandom_range(32767, 1)));
    random_phase(46, 1'b0);
    wait_idle();
    set_threshold(16'h7FFF);
    random_phase(0, 1'b0);
    wait_idle();
    repeat (TAIL_WAIT) @(negedge clk);

    if (expected_verdicts.size() != 0)
      flag_mismatch("results never arrived", expected_verdicts.size(), 0);
    if (err_count == 0) begin
      $display("byte_entropy_detector test passed");
    end else begin
      $display("byte_entropy_detector test failed");
    end
    $finish;
  end

endmodule
